// ===== hdl/pidl_pkg.sv =====
// ----------------------------------------------------------------------------
// pidl_pkg: shared definitions for the positional insert/delete list
// Widths, capacity, command codes and the broadcast bundle that drives the
// row of list cells.
// ----------------------------------------------------------------------------
package pidl_pkg;

	localparam int CAPACITY = 32;
	localparam int DATA_W   = 32;
	localparam int POS_W    = 6;
	localparam int COUNT_W  = 6;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [1:0] {
		CMD_READ   = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_WRITE  = 2'd3
	} cmd_t;

	// One accepted command as seen by every cell. The strobes are already
	// qualified by acceptance and by the range checks.
	typedef struct packed {
		logic                     rd;
		logic                     ins;
		logic                     del;
		logic                     wr;
		logic [IDX_W-1:0]         pos;
		logic signed [DATA_W-1:0] value;
	} bcast_t;

endpackage

// ===== hdl/pidl_req_if.sv =====
// ----------------------------------------------------------------------------
// pidl_req_if: command channel
// Valid/ready channel carrying one command word: cmd, position and value.
// ----------------------------------------------------------------------------
interface pidl_req_if;
	logic                                     valid;
	logic                                     ready;
	pidl_pkg::cmd_t                           cmd;
	logic [pidl_pkg::POS_W-1:0]               position;
	logic signed [pidl_pkg::DATA_W-1:0]       value;

	modport source (output valid, cmd, position, value, input ready);
	modport sink   (input valid, cmd, position, value, output ready);
endinterface

// ===== hdl/pidl_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pidl_rsp_if: response channel
// Valid/ready channel carrying one response word: ok, data and count.
// ----------------------------------------------------------------------------
interface pidl_rsp_if;
	logic                                     valid;
	logic                                     ready;
	logic                                     ok;
	logic signed [pidl_pkg::DATA_W-1:0]       data;
	logic [pidl_pkg::COUNT_W-1:0]             count;

	modport source (output valid, ok, data, count, input ready);
	modport sink   (input valid, ok, data, count, output ready);
endinterface

// ===== hdl/pidl_cell.sv =====
// ----------------------------------------------------------------------------
// pidl_cell: one list entry
// Holds the entry at a fixed index; shifts from its lower or upper neighbor,
// loads the command value, and feeds the read-out chain.
// ----------------------------------------------------------------------------
module pidl_cell (
	input  logic                               clk,
	input  logic [pidl_pkg::IDX_W-1:0]         idx,
	input  pidl_pkg::bcast_t                   bc,
	input  logic signed [pidl_pkg::DATA_W-1:0] left,
	input  logic signed [pidl_pkg::DATA_W-1:0] right,
	input  logic signed [pidl_pkg::DATA_W-1:0] rd_in,
	output logic signed [pidl_pkg::DATA_W-1:0] entry,
	output logic signed [pidl_pkg::DATA_W-1:0] rd_out
);
	import pidl_pkg::*;

	logic signed [DATA_W-1:0] entry_q;
	logic                     hit;
	logic                     above;

	always_comb begin
		hit   = (idx == bc.pos);
		above = (idx > bc.pos);
	end

	// Insert opens a gap at the position, delete closes it.
	always_ff @(posedge clk) begin
		if (bc.ins && above) begin
			entry_q <= left;
		end else if ((bc.ins || bc.wr) && hit) begin
			entry_q <= bc.value;
		end else if (bc.del && (hit || above)) begin
			entry_q <= right;
		end
	end

	assign entry  = entry_q;
	assign rd_out = rd_in | ((bc.rd && hit) ? entry_q : '0);

endmodule

// ===== hdl/positional_insert_delete_list_top.sv =====
// ----------------------------------------------------------------------------
// positional_insert_delete_list_top: ordered list with positional commands
// Fixed-capacity list of signed words with read, insert, delete and write at
// a position, built as a row of shifting cells.
// ----------------------------------------------------------------------------
// The list is a row of CAPACITY cells, one entry per cell, and every command
// word is finished in the cycle it is accepted: an insert moves all entries
// above the position up one cell and a delete moves them down one cell in the
// same clock edge, since every cell loads from its neighbor in parallel. The
// response word (ok, data, count) sits in a single output register, so the
// block takes one command word per cycle for as long as the response side
// takes words, and the response appears in the cycle after acceptance. Read and
// delete data come from an OR chain through the cells, which selects the old
// entry at the position. Rejected commands (position out of range, or an
// insert into a full list) return ok low, data zero and leave the list as it
// was. Entries hold no reset value; only positions below the count can ever
// be read, and each of those was written by an insert.
module positional_insert_delete_list_top (
	input  logic       clk,
	input  logic       arst_n,
	pidl_req_if.sink   req,
	pidl_rsp_if.source rsp
);
	import pidl_pkg::*;

	logic [CNT_W-1:0]         count_q;
	logic                     rsp_valid_q;
	logic                     ok_q;
	logic signed [DATA_W-1:0] data_q;
	logic [COUNT_W-1:0]       rsp_count_q;

	logic                     accept;
	logic [CMP_W-1:0]         pos_c;
	logic [CMP_W-1:0]         cnt_c;
	logic                     in_range;
	logic                     ins_ok;
	logic                     ok;
	logic [CNT_W-1:0]         count_nxt;
	bcast_t                   bc;

	logic signed [DATA_W-1:0] entry_w [CAPACITY];
	logic signed [DATA_W-1:0] rd_w    [CAPACITY+1];

	// The output register frees up whenever its word is being taken.
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	always_comb begin
		pos_c     = CMP_W'(req.position);
		cnt_c     = CMP_W'(count_q);
		in_range  = (pos_c < cnt_c);
		ins_ok    = (pos_c <= cnt_c) && (cnt_c < CMP_W'(CAPACITY));
		ok        = 1'b0;
		count_nxt = count_q;
		case (req.cmd)
			CMD_READ: begin
				ok = in_range;
			end
			CMD_INSERT: begin
				ok = ins_ok;
				if (ins_ok) begin
					count_nxt = count_q + CNT_W'(1);
				end
			end
			CMD_DELETE: begin
				ok = in_range;
				if (in_range) begin
					count_nxt = count_q - CNT_W'(1);
				end
			end
			CMD_WRITE: begin
				ok = in_range;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	// Broadcast to the cells. The position is only used when the command is
	// in range, and then it always fits the cell index.
	always_comb begin
		bc.rd    = accept && ok && (req.cmd inside {CMD_READ, CMD_DELETE});
		bc.ins   = accept && ok && (req.cmd == CMD_INSERT);
		bc.del   = accept && ok && (req.cmd == CMD_DELETE);
		bc.wr    = accept && ok && (req.cmd == CMD_WRITE);
		bc.pos   = req.position[IDX_W-1:0];
		bc.value = req.value;
	end

	assign rd_w[0] = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [DATA_W-1:0] left_w;
		logic signed [DATA_W-1:0] right_w;

		// The bottom cell never takes from below and the top cell never takes
		// from above; their outer ports are tied off.
		if (i == 0) begin : g_lo
			assign left_w = bc.value;
		end else begin : g_mid_lo
			assign left_w = entry_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_hi
			assign right_w = entry_w[i];
		end else begin : g_mid_hi
			assign right_w = entry_w[i+1];
		end

		pidl_cell u_cell (
			.clk    (clk),
			.idx    (IDX_W'(i)),
			.bc     (bc),
			.left   (left_w),
			.right  (right_w),
			.rd_in  (rd_w[i]),
			.entry  (entry_w[i]),
			.rd_out (rd_w[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q        <= ok;
			data_q      <= rd_w[CAPACITY];
			rsp_count_q <= COUNT_W'(count_nxt);
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.ok    = ok_q;
	assign rsp.data  = data_q;
	assign rsp.count = rsp_count_q;

	// The count never goes past the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// A rejected command carries zero data.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !ok_q |-> data_q == '0)
		else $error("rejected response with nonzero data");

	// A successful insert grows the list by exactly one entry.
	a_insert_grow: assert property (@(posedge clk) disable iff (!arst_n)
		bc.ins |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow the count by one");

	// A read or write never changes the count.
	a_rw_hold: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ((req.cmd == CMD_READ) || (req.cmd == CMD_WRITE)) |=> $stable(count_q))
		else $error("read or write changed the count");

endmodule

// ===== sim/pidl_list_checker.sv =====
// ----------------------------------------------------------------------------
// pidl_list_checker: response checker for the positional insert/delete list
// Watches both channels. Every accepted command word updates a private copy
// of the list and queues the response word it should produce. Every accepted
// response word is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module pidl_list_checker
	import pidl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	pidl_req_if  req,
	pidl_rsp_if  rsp,
	output int   failures,
	output int   pending
);

	typedef struct packed {
		logic                     ok;
		logic signed [DATA_W-1:0] data;
		logic [COUNT_W-1:0]       count;
	} list_reply_t;

	logic signed [DATA_W-1:0] cells [CAPACITY];
	int                       held;
	list_reply_t              replies_due [$];
	list_reply_t              seen;
	list_reply_t              due;

	// Applies one command to the private list and returns the response it earns.
	function automatic list_reply_t apply_command(cmd_t c, logic [POS_W-1:0] p,
		logic signed [DATA_W-1:0] v);
		list_reply_t r;
		int          i;
		r = '0;
		case (c)
			CMD_READ: begin
				if (p < held) begin
					r.data = cells[p];
					r.ok   = 1'b1;
				end
			end
			CMD_INSERT: begin
				if (p <= held && held < CAPACITY) begin
					for (i = held; i > p; i--)
						cells[i] = cells[i-1];
					cells[p] = v;
					held++;
					r.ok = 1'b1;
				end
			end
			CMD_DELETE: begin
				if (p < held) begin
					r.data = cells[p];
					for (i = p + 1; i < held; i++)
						cells[i-1] = cells[i];
					held--;
					r.ok = 1'b1;
				end
			end
			default: begin
				if (p < held) begin
					cells[p] = v;
					r.ok     = 1'b1;
				end
			end
		endcase
		r.count = held[COUNT_W-1:0];
		return r;
	endfunction

	task automatic report_failure(string what, list_reply_t want, list_reply_t got);
		failures++;
		if (failures <= 10)
			$display("list checker: %s at %0t: ok %0b/%0b data %0d/%0d count %0d/%0d",
				what, $realtime, want.ok, got.ok, want.data, got.data,
				want.count, got.count);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CAPACITY; k++)
				cells[k] = '0;
			held = 0;
			replies_due.delete();
			failures = 0;
			pending  = 0;
		end else begin
			// A response accepted at this edge belongs to an earlier command, so it
			// is checked before the command accepted at the same edge is queued.
			if (rsp.valid && rsp.ready) begin
				seen.ok    = rsp.ok;
				seen.data  = rsp.data;
				seen.count = rsp.count;
				if (replies_due.size() == 0) begin
					report_failure("response word with none due", '0, seen);
				end else begin
					due = replies_due.pop_front();
					if (seen.ok !== due.ok || seen.data !== due.data ||
						seen.count !== due.count)
						report_failure("response word differs (expected/actual)", due, seen);
				end
			end
			if (req.valid && req.ready)
				replies_due.push_back(apply_command(req.cmd, req.position, req.value));
			pending = replies_due.size();
		end
	end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench top for the positional insert/delete list
// Drives command words with random gaps, stalls the response channel at
// random, and leaves prediction and comparison to the list checker.
// ----------------------------------------------------------------------------
module tb;
	import pidl_pkg::*;

	// This bound only catches a block that stops answering.
	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_WORDS = 850;
	// Length of one stretch of random words that share a command mix.
	localparam int MIX_SPAN     = 48;

	// Command mixes for the random part: one that fills the list, one that
	// empties it, and one that leaves the count wandering.
	typedef enum logic [1:0] {
		MIX_GROW,
		MIX_SHRINK,
		MIX_EVEN
	} mix_t;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   words_due;
	int   cycles;

	// Rough count of list entries, kept only to aim positions near the valid
	// range. The checker holds the real prediction.
	int   aim_count;
	// While low, neither side of the testbench idles.
	bit   idle_en;

	pidl_req_if req_ch ();
	pidl_rsp_if rsp_ch ();

	positional_insert_delete_list_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	pidl_list_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.failures (fail_count),
		.pending  (words_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The response side takes a word in most cycles and stalls in about eight
	// of a hundred while idling is allowed.
	always @(posedge clk)
		rsp_ch.ready <= !idle_en || ($urandom_range(99) >= 8);

	// Offers one command word and holds it until the block takes it. A gap,
	// if one is drawn, lowers valid in this step and raises it again only in
	// a later one.
	task automatic send_word(cmd_t c, logic [POS_W-1:0] p, logic signed [DATA_W-1:0] v);
		while (idle_en && $urandom_range(99) < 8) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.cmd      <= c;
		req_ch.position <= p;
		req_ch.value    <= v;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		if (c == CMD_INSERT && p <= aim_count && aim_count < CAPACITY)
			aim_count++;
		else if (c == CMD_DELETE && p < aim_count)
			aim_count--;
	endtask

	// Stops offering words until every response due has been taken.
	task automatic drain_responses();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (words_due != 0)
			@(posedge clk);
	endtask

	function automatic cmd_t pick_command(mix_t mix);
		int r;
		r = $urandom_range(99);
		case (mix)
			MIX_GROW:   return r < 55 ? CMD_INSERT : r < 70 ? CMD_DELETE :
				r < 85 ? CMD_READ : CMD_WRITE;
			MIX_SHRINK: return r < 15 ? CMD_INSERT : r < 70 ? CMD_DELETE :
				r < 85 ? CMD_READ : CMD_WRITE;
			default:    return r < 30 ? CMD_INSERT : r < 60 ? CMD_DELETE :
				r < 80 ? CMD_READ : CMD_WRITE;
		endcase
	endfunction

	// Most positions fall inside the range the command accepts; some sit on
	// its edges and a few are drawn over the whole field, mostly rejected.
	function automatic logic [POS_W-1:0] pick_position(cmd_t c);
		int r;
		int top;
		r   = $urandom_range(99);
		top = (c == CMD_INSERT) ? aim_count : aim_count - 1;
		if (top < 0)
			top = 0;
		if (r < 80)
			return POS_W'($urandom_range(top));
		else if (r < 90)
			return POS_W'($urandom_range(1) ? 0 : aim_count + $urandom_range(1));
		else
			return POS_W'($urandom_range((1 << POS_W) - 1));
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(19))
			0:       return '0;
			1:       return '1;
			2:       return {1'b0, {(DATA_W-1){1'b1}}};
			3:       return {1'b1, {(DATA_W-1){1'b0}}};
			default: return $urandom;
		endcase
	endfunction

	// Watchdog: a run that outlives the limit has hung.
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("positional_insert_delete_list_top: mismatch");
		$finish;
	end

	initial begin
		mix_t mix;
		cmd_t c;
		arst_n          <= 1'b0;
		req_ch.valid    <= 1'b0;
		req_ch.cmd      <= CMD_READ;
		req_ch.position <= '0;
		req_ch.value    <= '0;
		aim_count = 0;
		idle_en   = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. On the empty list every read, delete and write is
		// rejected, and so is an insert past the end.
		send_word(CMD_READ,   6'd0, 32'sd5);
		send_word(CMD_DELETE, 6'd0, 32'sd7);
		send_word(CMD_WRITE,  6'd0, 32'sd1);
		send_word(CMD_INSERT, 6'd1, 32'sd3);
		// Fill with the extreme words: first entry, push at the front, push at
		// the back, then an insert in the middle that moves two entries up.
		send_word(CMD_INSERT, 6'd0, 32'sh7FFF_FFFF);
		send_word(CMD_INSERT, 6'd0, 32'sh8000_0000);
		send_word(CMD_INSERT, 6'd2, -32'sd1);
		send_word(CMD_INSERT, 6'd1, 32'sd0);
		// Reads at both ends; a read at the count and one at the top of the
		// position field are both out of range.
		send_word(CMD_READ,   6'd0, 32'sh1234_5678);
		send_word(CMD_READ,   6'd3, -32'sd9);
		send_word(CMD_READ,   6'd4, 32'sd0);
		send_word(CMD_READ,   6'd63, 32'sd0);
		// Overwrite in place and read it back; writing at the count is refused.
		send_word(CMD_WRITE,  6'd2, 32'sh5555_5555);
		send_word(CMD_READ,   6'd2, 32'sd0);
		send_word(CMD_WRITE,  6'd4, 32'sd11);
		// Inserts beyond the count, one just past it and one far out.
		send_word(CMD_INSERT, 6'd63, 32'sd12);
		send_word(CMD_INSERT, 6'd5, 32'sd13);
		// Pop from the front and the back, then a delete far out of range.
		send_word(CMD_DELETE, 6'd0, 32'sd0);
		send_word(CMD_DELETE, 6'd2, 32'sd0);
		send_word(CMD_DELETE, 6'd63, 32'sd0);
		// Insert and delete in the middle, then clear the head entry.
		send_word(CMD_INSERT, 6'd1, 32'shAAAA_AAAA);
		send_word(CMD_DELETE, 6'd1, -32'sd1);
		send_word(CMD_WRITE,  6'd0, 32'sd0);

		// Let every response of the directed part come back before going on.
		drain_responses();

		// Random part. The first two stretches fill the list and keep pressing
		// on a full one, the third empties it again, and later stretches pick a
		// mix at random so the count swings between empty and full.
		mix = MIX_GROW;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % MIX_SPAN == 0)
				mix = (n < 2 * MIX_SPAN) ? MIX_GROW :
					(n < 3 * MIX_SPAN) ? MIX_SHRINK : mix_t'($urandom_range(2));
			// A long stretch with no idling on either side.
			idle_en = !(n >= 300 && n < 450);
			// Pause with the list at rest a couple of times.
			if (n == 500 || n == 700)
				drain_responses();
			c = pick_command(mix);
			send_word(c, pick_position(c), pick_value());
		end

		drain_responses();
		repeat (5) @(posedge clk);
		if (fail_count == 0 && words_due == 0)
			$display("positional_insert_delete_list_top: match");
		else
			$display("positional_insert_delete_list_top: mismatch");
		$finish;
	end

endmodule
